// File: design/scfp_pkg.sv
// Shared types and constants for the sync/checksum frame parser.
package scfp_pkg;

	localparam logic [7:0] SYNC_BYTE   = 8'hAA;
	localparam int         FIELD_COUNT = 15;
	localparam int         FIELD_W     = 4;
	localparam int         STATUS_W    = 2;
	localparam int         VALUE_W     = 16;
	localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(FIELD_COUNT - 1);

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD_HDR = 2'd1,
		STAT_BAD_SUM = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_HUNT,
		S_COLLECT,
		S_EMIT
	} fsm_t;

	typedef struct packed {
		logic shift1;
		logic shift2;
	} chain_ctl_t;

endpackage

// File: design/scfp_cell.sv
// One byte cell of the frame shift chain.
module scfp_cell import scfp_pkg::*; (
	input  logic       clk,
	input  chain_ctl_t ctl,
	input  logic [7:0] d1,
	input  logic [7:0] d2,
	output logic [7:0] q
);

	logic [7:0] data_q;

	// shift1: new byte enters; shift2: drain two bytes per field
	always_ff @(posedge clk) begin
		if (ctl.shift1) begin
			data_q <= d1;
		end else if (ctl.shift2) begin
			data_q <= d2;
		end
	end

	assign q = data_q;

endmodule

// File: design/scfp_chain.sv
// Row of byte cells holding all frame bytes but the checksum byte.
module scfp_chain import scfp_pkg::*; #(
	parameter int CELLS = 34
) (
	input  logic       clk,
	input  chain_ctl_t ctl,
	input  logic [7:0] byte_in,
	output logic [7:0] hdr_byte,
	output logic [7:0] hi_byte,
	output logic [7:0] lo_byte
);

	logic [7:0] q [CELLS];

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		logic [7:0] d1;
		logic [7:0] d2;
		if (i == 0) begin : g_head
			assign d1 = byte_in;
			assign d2 = 8'd0;
		end else if (i == 1) begin : g_second
			assign d1 = q[i-1];
			assign d2 = 8'd0;
		end else begin : g_body
			assign d1 = q[i-1];
			assign d2 = q[i-2];
		end
		scfp_cell u_cell (
			.clk (clk),
			.ctl (ctl),
			.d1  (d1),
			.d2  (d2),
			.q   (q[i])
		);
	end

	// byte 0 ends in the far cell; byte 1 next to it, field bytes from byte 4 on
	assign hdr_byte = q[CELLS-2];
	assign hi_byte  = q[CELLS-5];
	assign lo_byte  = q[CELLS-6];

endmodule

// File: design/sync_checksum_frame_parser.sv
// Output: a bad frame's result is registered as its last byte is taken; a good frame's
// fields pass the S_EMIT state, then the output register, one field per cycle while m_tready is high.
// Throughput: one byte per cycle while hunting or collecting, the closing byte waiting for a free
// output slot; input stalls while the 15 fields are drained, two chain cells per beat from a fixed tap.
// Reset: arst_n clears the FSM, counters, sum and output valid; the byte chain is not reset.
module sync_checksum_frame_parser import scfp_pkg::*; #(
	parameter int FRAME_BYTES = 35
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] field_index, [19:4] field_value, [23:20] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	localparam int CNT_W = $clog2(FRAME_BYTES);
	localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_BYTES - 1);

	fsm_t                 state_q, state_nxt;
	logic [CNT_W-1:0]     cnt_q;
	logic [7:0]           sum_q;
	logic [FIELD_W-1:0]   field_q;
	logic                 m_valid_q;
	status_t              status_q;
	logic [FIELD_W-1:0]   index_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 last_q;

	logic       slot_free, accept, final_byte, hdr_bad, sum_bad;
	logic       load_err, load_field;
	chain_ctl_t ctl;
	logic [7:0] hdr_byte, hi_byte, lo_byte;

	scfp_chain #(
		.CELLS (FRAME_BYTES - 1)
	) u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.byte_in  (s_tdata),
		.hdr_byte (hdr_byte),
		.hi_byte  (hi_byte),
		.lo_byte  (lo_byte)
	);

	assign slot_free  = !m_valid_q || m_tready;
	assign final_byte = (state_q == S_COLLECT) && (cnt_q == LAST_POS);
	assign hdr_bad    = hdr_byte != SYNC_BYTE;
	assign sum_bad    = sum_q != s_tdata;

	always_comb begin
		s_tready   = 1'b0;
		ctl        = '0;
		load_err   = 1'b0;
		load_field = 1'b0;
		case (state_q)
			S_HUNT: begin
				s_tready   = 1'b1;
				ctl.shift1 = s_tvalid && (s_tdata == SYNC_BYTE);
			end
			S_COLLECT: begin
				// the closing byte may produce a result, so it needs the output slot
				s_tready   = !final_byte || slot_free;
				ctl.shift1 = s_tvalid && s_tready && !final_byte;
				load_err   = s_tvalid && s_tready && final_byte && (hdr_bad || sum_bad);
			end
			S_EMIT: begin
				load_field = slot_free;
				ctl.shift2 = slot_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_HUNT: begin
				if (accept && s_tdata == SYNC_BYTE) begin
					state_nxt = S_COLLECT;
				end
			end
			S_COLLECT: begin
				if (accept && final_byte) begin
					state_nxt = (hdr_bad || sum_bad) ? S_HUNT : S_EMIT;
				end
			end
			S_EMIT: begin
				if (load_field && field_q == LAST_FIELD) begin
					state_nxt = S_HUNT;
				end
			end
			default: begin
				state_nxt = S_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
			cnt_q   <= '0;
			sum_q   <= '0;
			field_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctl.shift1) begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_q + s_tdata;
			end else if (accept && final_byte) begin
				cnt_q <= '0;
				sum_q <= '0;
			end
			if (load_field) begin
				field_q <= (field_q == LAST_FIELD) ? '0 : field_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_err || load_field) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_err) begin
			status_q <= hdr_bad ? STAT_BAD_HDR : STAT_BAD_SUM;
			index_q  <= '0;
			value_q  <= '0;
			last_q   <= 1'b1;
		end else if (load_field) begin
			status_q <= STAT_OK;
			index_q  <= field_q;
			value_q  <= {hi_byte, lo_byte};
			last_q   <= field_q == LAST_FIELD;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, value_q, index_q};
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

endmodule

// File: design/scfp_checker.sv
// Port-level assertions for the frame parser, bound to the top level.
module scfp_checker import scfp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output beat changed");

	// error results are single, zeroed beats
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STAT_OK |-> m_tlast && m_tdata == 24'd0)
		else $error("error beat not last or not zero");

	// input is held off while a field burst is still going
	a_burst_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_OK && !m_tlast |-> !s_tready)
		else $error("input taken during field burst");

	// field beats step through the index in order
	a_field_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser == STAT_OK && !m_tlast
		|=> m_tvalid && m_tuser == STAT_OK
			&& m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1)
		else $error("field burst out of order");

	// the closing field carries the last index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_OK |-> m_tlast == (m_tdata[3:0] == LAST_FIELD))
		else $error("tlast does not match last field");

endmodule

bind sync_checksum_frame_parser scfp_checker u_scfp_checker (.*);
